>>> design/imu_sfd_pkg.sv
// shared types, constants and register codes for the imu serial frame decoder
// no dependencies
package imu_sfd_pkg;

  localparam int unsigned FifoDepth = 4;

  localparam logic [7:0] HeaderByte = 8'h55;
  localparam logic [7:0] TypeLow    = 8'h50;
  localparam logic [7:0] TypeHigh   = 8'h5A;
  localparam logic [7:0] TypeAccel  = 8'h51;
  localparam logic [7:0] TypeGyro   = 8'h52;
  localparam logic [7:0] TypeAngle  = 8'h53;

  localparam logic [3:0] PosHeader = 4'd0;
  localparam logic [3:0] PosType   = 4'd1;
  localparam logic [3:0] PosFirst  = 4'd2;
  localparam logic [3:0] PosCheck  = 4'd10;

  localparam logic [31:0] AccelScaleRst    = 32'd20566036;
  localparam logic [31:0] GyroScaleRst     = 32'd4575276;
  localparam logic [31:0] AngleScaleRst    = 32'd23592960;
  localparam logic [31:0] TempScaleRst     = 32'd42949673;
  localparam logic [15:0] StaleLimitRst    = 16'd1000;
  localparam logic [15:0] ProbeIntervalRst = 16'd1500;

  typedef enum logic [2:0] {
    KIND_ACCEL = 3'd0,
    KIND_GYRO  = 3'd1,
    KIND_ANGLE = 3'd2,
    KIND_STAMP = 3'd3,
    KIND_BAUD  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CFG_ACCEL_SCALE    = 3'd0,
    CFG_GYRO_SCALE     = 3'd1,
    CFG_ANGLE_SCALE    = 3'd2,
    CFG_TEMP_SCALE     = 3'd3,
    CFG_STALE_LIMIT    = 3'd4,
    CFG_PROBE_INTERVAL = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] accel_scale;
    logic [31:0] gyro_scale;
    logic [31:0] angle_scale;
    logic [31:0] temp_scale;
    logic [15:0] stale_limit;
    logic [15:0] probe_interval;
  } cfg_t;

  // frame kinds carry eight raw bytes; stamp and baud carry time and rate bit
  typedef struct packed {
    kind_e       kind;
    logic [63:0] payload;
  } job_t;

endpackage

>>> design/imu_serial_frame_decoder_top.sv
// top level of the imu serial frame decoder: configuration registers and wiring
// depends on imu_sfd_pkg, imu_sfd_front, imu_sfd_fifo, imu_sfd_back
//
// input channel (in_valid_i / in_stall_o): one item per cycle unless stalled:
// a received byte (req_type_i 0) or a millisecond tick (req_type_i 1, now_ms_i)
// output channel (out_valid_o / out_stall_i): zero or one result item per input
// item, in input order: scaled accel, gyro, angle frames, angle stamps and baud
// switch requests
// config channel (cfg_valid_i / cfg_ready_o): always ready, write only while idle
// path: an accepted item passes through the job queue entry, the multiplier
// register and the output register before out_valid_o rises
// throughput: one item per cycle unless the receiver stalls; the four 16x33
// scaling multipliers run in parallel in one stage
// reset: parser at header search, link unlocked, fast rate assumed, queue empty,
// config at its default scales and timeouts
// receiver stall: the output register holds, the multiplier stage and the job
// queue fill, and in_stall_o rises once the queue is full
module imu_serial_frame_decoder_top #(
  parameter int unsigned FifoDepth = imu_sfd_pkg::FifoDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [31:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic signed [31:0] value_x_o,
  output logic signed [31:0] value_y_o,
  output logic signed [31:0] value_z_o,
  output logic signed [31:0] temperature_o,
  output logic [31:0]        stamp_ms_o,
  output logic               use_fast_baud_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  imu_sfd_pkg::cfg_t cfg_q;
  imu_sfd_pkg::job_t push_job;
  imu_sfd_pkg::job_t head_job;
  logic              push;
  logic              full;
  logic              pop;
  logic              head_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_scale    <= imu_sfd_pkg::AccelScaleRst;
      cfg_q.gyro_scale     <= imu_sfd_pkg::GyroScaleRst;
      cfg_q.angle_scale    <= imu_sfd_pkg::AngleScaleRst;
      cfg_q.temp_scale     <= imu_sfd_pkg::TempScaleRst;
      cfg_q.stale_limit    <= imu_sfd_pkg::StaleLimitRst;
      cfg_q.probe_interval <= imu_sfd_pkg::ProbeIntervalRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (imu_sfd_pkg::cfg_idx_e'(cfg_index_i))
        imu_sfd_pkg::CFG_ACCEL_SCALE:    cfg_q.accel_scale    <= cfg_data_i;
        imu_sfd_pkg::CFG_GYRO_SCALE:     cfg_q.gyro_scale     <= cfg_data_i;
        imu_sfd_pkg::CFG_ANGLE_SCALE:    cfg_q.angle_scale    <= cfg_data_i;
        imu_sfd_pkg::CFG_TEMP_SCALE:     cfg_q.temp_scale     <= cfg_data_i;
        imu_sfd_pkg::CFG_STALE_LIMIT:    cfg_q.stale_limit    <= cfg_data_i[15:0];
        imu_sfd_pkg::CFG_PROBE_INTERVAL: cfg_q.probe_interval <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  imu_sfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (in_valid_i),
    .item_stall_o (in_stall_o),
    .req_type_i   (req_type_i),
    .rx_byte_i    (rx_byte_i),
    .now_ms_i     (now_ms_i),
    .full_i       (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  imu_sfd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  imu_sfd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .job_valid_i     (head_valid),
    .job_i           (head_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .value_x_o       (value_x_o),
    .value_y_o       (value_y_o),
    .value_z_o       (value_z_o),
    .temperature_o   (temperature_o),
    .stamp_ms_o      (stamp_ms_o),
    .use_fast_baud_o (use_fast_baud_o)
  );

endmodule

>>> design/imu_sfd_front.sv
// front end: frame hunter, checksum, angle stamping, link watchdog, baud probe
// depends on imu_sfd_pkg
module imu_sfd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  imu_sfd_pkg::cfg_t  cfg_i,
  input  logic               item_valid_i,
  output logic               item_stall_o,
  input  logic               req_type_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [31:0]        now_ms_i,
  input  logic               full_i,
  output logic               push_o,
  output imu_sfd_pkg::job_t  job_o
);

  logic [3:0]  pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic        pending_q, pending_d;
  logic        locked_q, locked_d;
  logic [31:0] lat_q, lat_d;
  logic [31:0] lst_q, lst_d;
  logic        fast_q, fast_d;
  logic [7:0]  type_q;
  logic [7:0]  data_q [8];

  logic        accept;
  logic        data_we;
  logic        type_we;
  logic [2:0]  data_idx;
  logic [15:0] limit;
  logic [31:0] since_angle;
  logic [31:0] since_switch;
  logic        drop;
  logic        toggle;

  assign item_stall_o = full_i;
  assign accept       = item_valid_i && !full_i;
  assign data_idx     = 3'(pos_q - imu_sfd_pkg::PosFirst);

  assign limit        = (cfg_i.stale_limit == 16'd0) ? 16'd1 : cfg_i.stale_limit;
  assign since_angle  = now_ms_i - lat_q;
  assign since_switch = now_ms_i - lst_q;
  assign drop         = locked_q && (since_angle >= {16'd0, limit});
  assign toggle       = !locked_q ? (since_switch >= {16'd0, cfg_i.probe_interval})
                                  : (drop && (cfg_i.probe_interval == 16'd0));

  always_comb begin
    pos_d     = pos_q;
    sum_d     = sum_q;
    pending_d = pending_q;
    locked_d  = locked_q;
    lat_d     = lat_q;
    lst_d     = lst_q;
    fast_d    = fast_q;
    data_we   = 1'b0;
    type_we   = 1'b0;
    push_o    = 1'b0;
    job_o     = '{kind: imu_sfd_pkg::KIND_ACCEL, payload: '0};
    if (accept && !req_type_i) begin
      case (pos_q)
        imu_sfd_pkg::PosHeader: begin
          if (rx_byte_i == imu_sfd_pkg::HeaderByte) begin
            sum_d = rx_byte_i;
            pos_d = imu_sfd_pkg::PosType;
          end
        end
        imu_sfd_pkg::PosType: begin
          if (rx_byte_i >= imu_sfd_pkg::TypeLow && rx_byte_i <= imu_sfd_pkg::TypeHigh) begin
            type_we = 1'b1;
            sum_d   = sum_q + rx_byte_i;
            pos_d   = imu_sfd_pkg::PosFirst;
          end else begin
            pos_d = imu_sfd_pkg::PosHeader;
          end
        end
        imu_sfd_pkg::PosCheck: begin
          pos_d = imu_sfd_pkg::PosHeader;
          job_o.payload = {data_q[7], data_q[6], data_q[5], data_q[4],
                           data_q[3], data_q[2], data_q[1], data_q[0]};
          if (sum_q == rx_byte_i) begin
            if (type_q == imu_sfd_pkg::TypeAccel) begin
              push_o     = 1'b1;
              job_o.kind = imu_sfd_pkg::KIND_ACCEL;
            end else if (type_q == imu_sfd_pkg::TypeGyro) begin
              push_o     = 1'b1;
              job_o.kind = imu_sfd_pkg::KIND_GYRO;
            end else if (type_q == imu_sfd_pkg::TypeAngle) begin
              push_o     = 1'b1;
              job_o.kind = imu_sfd_pkg::KIND_ANGLE;
              pending_d  = 1'b1;
            end
          end
        end
        default: begin
          if (pos_q < imu_sfd_pkg::PosCheck) begin
            data_we = 1'b1;
            sum_d   = sum_q + rx_byte_i;
            pos_d   = pos_q + 4'd1;
          end else begin
            pos_d = imu_sfd_pkg::PosHeader;
          end
        end
      endcase
    end else if (accept && req_type_i) begin
      if (pending_q) begin
        pending_d  = 1'b0;
        lat_d      = now_ms_i;
        locked_d   = 1'b1;
        push_o     = 1'b1;
        job_o.kind = imu_sfd_pkg::KIND_STAMP;
        job_o.payload[31:0] = (now_ms_i == 32'd0) ? 32'd1 : now_ms_i;
      end else begin
        if (drop) begin
          locked_d = 1'b0;
          lst_d    = now_ms_i;
        end
        if (toggle) begin
          fast_d     = !fast_q;
          pos_d      = imu_sfd_pkg::PosHeader;
          sum_d      = 8'd0;
          pending_d  = 1'b0;
          lat_d      = 32'd0;
          lst_d      = now_ms_i;
          push_o     = 1'b1;
          job_o.kind = imu_sfd_pkg::KIND_BAUD;
          job_o.payload[32:0] = {!fast_q, now_ms_i};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= imu_sfd_pkg::PosHeader;
      sum_q     <= 8'd0;
      pending_q <= 1'b0;
      locked_q  <= 1'b0;
      lat_q     <= 32'd0;
      lst_q     <= 32'd0;
      fast_q    <= 1'b1;
    end else begin
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      pending_q <= pending_d;
      locked_q  <= locked_d;
      lat_q     <= lat_d;
      lst_q     <= lst_d;
      fast_q    <= fast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (type_we) begin
      type_q <= rx_byte_i;
    end
    if (data_we) begin
      data_q[data_idx] <= rx_byte_i;
    end
  end

endmodule

>>> design/imu_sfd_fifo.sv
// short job queue between the front end and the scaling back end
// depends on imu_sfd_pkg
module imu_sfd_fifo #(
  parameter int unsigned Depth = imu_sfd_pkg::FifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  imu_sfd_pkg::job_t job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output imu_sfd_pkg::job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  imu_sfd_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("job pushed into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt)
    else $error("queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   push_i && !pop_i |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue lost a pushed job");

endmodule

>>> design/imu_sfd_back.sv
// back end: Q16.16 scaling multipliers and the output register
// depends on imu_sfd_pkg
module imu_sfd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  imu_sfd_pkg::cfg_t  cfg_i,
  input  logic               job_valid_i,
  input  imu_sfd_pkg::job_t  job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic signed [31:0] value_x_o,
  output logic signed [31:0] value_y_o,
  output logic signed [31:0] value_z_o,
  output logic signed [31:0] temperature_o,
  output logic [31:0]        stamp_ms_o,
  output logic               use_fast_baud_o
);

  logic                s1_valid_q;
  imu_sfd_pkg::kind_e  s1_kind_q;
  logic [32:0]         s1_meta_q;
  logic signed [48:0]  s1_prod_q [4];

  logic                out_valid_q;
  imu_sfd_pkg::kind_e  out_kind_q;
  logic signed [31:0]  x_q, y_q, z_q, t_q;
  logic [31:0]         stamp_q;
  logic                fast_q;

  logic [31:0]         scale;
  logic signed [48:0]  prod [4];
  logic                advance;
  logic                s1_ready;
  logic                s1_frame;

  always_comb begin
    case (job_i.kind)
      imu_sfd_pkg::KIND_GYRO:  scale = cfg_i.gyro_scale;
      imu_sfd_pkg::KIND_ANGLE: scale = cfg_i.angle_scale;
      default:                 scale = cfg_i.accel_scale;
    endcase
  end

  assign prod[0] = $signed(job_i.payload[15:0])  * $signed({1'b0, scale});
  assign prod[1] = $signed(job_i.payload[31:16]) * $signed({1'b0, scale});
  assign prod[2] = $signed(job_i.payload[47:32]) * $signed({1'b0, scale});
  assign prod[3] = $signed(job_i.payload[63:48]) * $signed({1'b0, cfg_i.temp_scale});

  assign advance  = !out_valid_q || !out_stall_i;
  assign s1_ready = !s1_valid_q || advance;
  assign pop_o    = job_valid_i && s1_ready;
  assign s1_frame = (s1_kind_q == imu_sfd_pkg::KIND_ACCEL) ||
                    (s1_kind_q == imu_sfd_pkg::KIND_GYRO)  ||
                    (s1_kind_q == imu_sfd_pkg::KIND_ANGLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= job_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_kind_q <= job_i.kind;
      s1_meta_q <= job_i.payload[32:0];
      s1_prod_q <= prod;
    end
    if (advance && s1_valid_q) begin
      out_kind_q <= s1_kind_q;
      x_q        <= s1_frame ? s1_prod_q[0][47:16] : 32'sd0;
      y_q        <= s1_frame ? s1_prod_q[1][47:16] : 32'sd0;
      z_q        <= s1_frame ? s1_prod_q[2][47:16] : 32'sd0;
      t_q        <= (s1_kind_q == imu_sfd_pkg::KIND_ACCEL) ? s1_prod_q[3][47:16] : 32'sd0;
      stamp_q    <= s1_frame ? 32'd0 : s1_meta_q[31:0];
      fast_q     <= (s1_kind_q == imu_sfd_pkg::KIND_BAUD) && s1_meta_q[32];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_kind_q;
  assign value_x_o       = x_q;
  assign value_y_o       = y_q;
  assign value_z_o       = z_q;
  assign temperature_o   = t_q;
  assign stamp_ms_o      = stamp_q;
  assign use_fast_baud_o = fast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q && out_kind_q != imu_sfd_pkg::KIND_BAUD |-> !fast_q)
    else $error("rate bit set on a non-baud item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q && out_kind_q != imu_sfd_pkg::KIND_ACCEL |-> t_q == 32'sd0)
    else $error("temperature set on a non-accel item");

endmodule

>>> dv/tb_imu_serial_frame_decoder_top.sv
// self-checking testbench for imu_serial_frame_decoder_top: directed table, then random frames
// and ticks over several register settings, checked against a cycle-free predictor
// depends on imu_sfd_pkg and the imu serial frame decoder rtl
`timescale 1ns / 1ps

module tb_imu_serial_frame_decoder_top;
  import imu_sfd_pkg::*;

  localparam int DrainCycles = 12;
  localparam int HoldCycles  = 300;
  localparam int PhaseItems  = 180;
  localparam int CycleLimit  = 200000;

  localparam logic [7:0] TypeBelow = 8'h4F;
  localparam logic [7:0] TypeMag   = 8'h54;
  localparam logic [2:0] CfgSpare6 = 3'd6;
  localparam logic [2:0] CfgSpare7 = 3'd7;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] temp;
    logic [31:0] stamp;
    logic        fast;
  } decoded_t;

  typedef enum logic [1:0] {ROW_TICK, ROW_FRAME, ROW_CFG} row_op_e;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} row_exp_e;

  typedef struct {
    row_op_e     op;
    logic [7:0]  code;
    logic [63:0] data;
    bit          bad;
    logic [31:0] now;
    row_exp_e    chk;
    decoded_t    res;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               req_type_i = 1'b0;
  logic [7:0]         rx_byte_i = '0;
  logic [31:0]        now_ms_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         kind_o;
  logic signed [31:0] value_x_o;
  logic signed [31:0] value_y_o;
  logic signed [31:0] value_z_o;
  logic signed [31:0] temperature_o;
  logic [31:0]        stamp_ms_o;
  logic               use_fast_baud_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;

  imu_serial_frame_decoder_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .rx_byte_i      (rx_byte_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .value_x_o      (value_x_o),
    .value_y_o      (value_y_o),
    .value_z_o      (value_z_o),
    .temperature_o  (temperature_o),
    .stamp_ms_o     (stamp_ms_o),
    .use_fast_baud_o(use_fast_baud_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of registers and decoder state
  logic [31:0] scale_accel = AccelScaleRst;
  logic [31:0] scale_gyro  = GyroScaleRst;
  logic [31:0] scale_angle = AngleScaleRst;
  logic [31:0] scale_temp  = TempScaleRst;
  logic [15:0] stale_ms    = StaleLimitRst;
  logic [15:0] probe_ms    = ProbeIntervalRst;

  logic [3:0]  hunt_pos = PosHeader;
  logic [7:0]  frame_buf [11];
  logic [7:0]  frame_sum = '0;
  bit          angle_due = 1'b0;
  bit          locked = 1'b0;
  logic [31:0] angle_ms = '0;
  logic [31:0] switch_ms = '0;
  bit          fast_sel = 1'b1;

  decoded_t    decoded_q [$];
  bit          follow_model = 1'b1;
  int          items_sent = 0;
  int          err_count = 0;
  int          cycle_cnt = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  logic [31:0] clock_ms = '0;
  logic        rx_hold = 1'b0;
  event        hold_ev;

  function automatic logic [31:0] to_q16(input logic [15:0] raw, input logic [31:0] scale);
    logic signed [48:0] prod;
    prod = $signed(raw) * $signed({1'b0, scale});
    return prod[47:16];
  endfunction

  function automatic bit decode_item(input logic typ, input logic [7:0] b,
                                     input logic [31:0] now, output decoded_t r);
    logic [31:0] sc;
    logic [15:0] limit;
    r = '0;
    if (!typ) begin
      if (hunt_pos == PosHeader) begin
        if (b == HeaderByte) begin
          frame_buf[0] = b;
          frame_sum = b;
          hunt_pos = PosType;
        end
        return 1'b0;
      end
      if (hunt_pos == PosType) begin
        if (b >= TypeLow && b <= TypeHigh) begin
          frame_buf[1] = b;
          frame_sum += b;
          hunt_pos = PosFirst;
        end else begin
          hunt_pos = PosHeader;
        end
        return 1'b0;
      end
      frame_buf[hunt_pos] = b;
      if (hunt_pos != PosCheck) begin
        frame_sum += b;
        hunt_pos += 4'd1;
        return 1'b0;
      end
      hunt_pos = PosHeader;
      if (frame_sum != b) return 1'b0;
      case (frame_buf[1])
        TypeAccel: begin
          sc = scale_accel;
          r.kind = KIND_ACCEL;
        end
        TypeGyro: begin
          sc = scale_gyro;
          r.kind = KIND_GYRO;
        end
        TypeAngle: begin
          sc = scale_angle;
          r.kind = KIND_ANGLE;
        end
        default: return 1'b0;
      endcase
      r.x = to_q16({frame_buf[3], frame_buf[2]}, sc);
      r.y = to_q16({frame_buf[5], frame_buf[4]}, sc);
      r.z = to_q16({frame_buf[7], frame_buf[6]}, sc);
      if (r.kind == KIND_ACCEL) r.temp = to_q16({frame_buf[9], frame_buf[8]}, scale_temp);
      if (r.kind == KIND_ANGLE) angle_due = 1'b1;
      return 1'b1;
    end
    limit = (stale_ms == 16'd0) ? 16'd1 : stale_ms;
    if (angle_due) begin
      angle_due = 1'b0;
      angle_ms = now;
      locked = 1'b1;
      r.kind = KIND_STAMP;
      r.stamp = (now == 32'd0) ? 32'd1 : now;
      return 1'b1;
    end
    if (locked && (now - angle_ms) >= limit) begin
      locked = 1'b0;
      switch_ms = now;
    end
    if (!locked && (now - switch_ms) >= probe_ms) begin
      fast_sel = !fast_sel;
      hunt_pos = PosHeader;
      frame_sum = '0;
      angle_due = 1'b0;
      angle_ms = '0;
      switch_ms = now;
      r.kind = KIND_BAUD;
      r.stamp = now;
      r.fast = fast_sel;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic check_result();
    decoded_t e;
    if (decoded_q.size() == 0) begin
      flag_error($sformatf("unexpected item of kind %0d", kind_o));
      return;
    end
    e = decoded_q.pop_front();
    check_field("kind", 32'(kind_o), 32'(e.kind));
    check_field("value_x", value_x_o, e.x);
    check_field("value_y", value_y_o, e.y);
    check_field("value_z", value_z_o, e.z);
    check_field("temperature", temperature_o, e.temp);
    check_field("stamp_ms", stamp_ms_o, e.stamp);
    check_field("use_fast_baud", 32'(use_fast_baud_o), 32'(e.fast));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
    out_stall_i <= rx_hold || ($urandom_range(99) < rcv_idle_pct);
  end

  initial begin
    forever begin
      @(hold_ev);
      rx_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_item(input logic typ, input logic [7:0] b, input logic [31:0] now);
    decoded_t r;
    bit has;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= typ;
    rx_byte_i  <= b;
    now_ms_i   <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    has = decode_item(typ, b, now, r);
    if (has && follow_model) decoded_q.push_back(r);
    items_sent++;
  endtask

  task automatic send_tick(input logic [31:0] now);
    send_item(1'b1, 8'($urandom), now);
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [63:0] data, input bit bad);
    logic [7:0] sum;
    sum = HeaderByte + ftype;
    send_item(1'b0, HeaderByte, $urandom);
    send_item(1'b0, ftype, $urandom);
    for (int k = 0; k < 8; k++) begin
      sum += data[8*k +: 8];
      send_item(1'b0, data[8*k +: 8], $urandom);
    end
    if (bad) sum ^= 8'($urandom_range(1, 255));
    send_item(1'b0, sum, $urandom);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_ACCEL_SCALE:    scale_accel = data;
      CFG_GYRO_SCALE:     scale_gyro = data;
      CFG_ANGLE_SCALE:    scale_angle = data;
      CFG_TEMP_SCALE:     scale_temp = data;
      CFG_STALE_LIMIT:    stale_ms = data[15:0];
      CFG_PROBE_INTERVAL: probe_ms = data[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] accel, input logic [31:0] gyro,
                            input logic [31:0] angle, input logic [31:0] temp,
                            input logic [31:0] stale, input logic [31:0] probe);
    drain();
    write_reg(CFG_ACCEL_SCALE, accel);
    write_reg(CFG_GYRO_SCALE, gyro);
    write_reg(CFG_ANGLE_SCALE, angle);
    write_reg(CFG_TEMP_SCALE, temp);
    write_reg(CFG_STALE_LIMIT, stale);
    write_reg(CFG_PROBE_INTERVAL, probe);
    write_reg(CfgSpare6, $urandom);
    write_reg(CfgSpare7, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    int s;
    s = $urandom_range(19);
    if (s == 0) return 8'($urandom);
    if (s < 4) return 8'($urandom_range(TypeLow, TypeHigh));
    return 8'(TypeAccel + $urandom_range(2));
  endfunction

  function automatic logic [31:0] next_now(input int step_max);
    if ($urandom_range(99) < 3) clock_ms = $urandom;
    else clock_ms += $urandom_range(step_max);
    return clock_ms;
  endfunction

  task automatic run_phase(input int n, input int step_max, input bit hold);
    int stop_at;
    int pick;
    stop_at = items_sent + n;
    if (hold) -> hold_ev;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_frame(pick_type(), {pick_word(), pick_word(), pick_word(), pick_word()},
                   $urandom_range(99) < 8);
      end else if (pick < 80) begin
        send_tick(next_now(step_max));
      end else if (pick < 90) begin
        send_item(1'b0, HeaderByte, $urandom);
        send_item(1'b0, pick_type(), $urandom);
        repeat ($urandom_range(8)) send_item(1'b0, 8'($urandom), $urandom);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(1'b0, ($urandom_range(3) == 0) ? HeaderByte : 8'($urandom), $urandom);
        end
      end
    end
  endtask

  function automatic decoded_t mk_result(input kind_e kind, input logic [31:0] stamp,
                                         input logic fast);
    decoded_t r;
    r = '0;
    r.kind = kind;
    r.stamp = stamp;
    r.fast = fast;
    return r;
  endfunction

  function automatic row_t tick_row(input logic [31:0] now, input row_exp_e chk,
                                    input decoded_t res);
    row_t w;
    w = '{op: ROW_TICK, code: '0, data: '0, bad: 1'b0, now: now, chk: chk, res: res};
    return w;
  endfunction

  function automatic row_t frame_row(input logic [7:0] ftype, input logic [63:0] data,
                                     input bit bad, input row_exp_e chk, input decoded_t res);
    row_t w;
    w = '{op: ROW_FRAME, code: ftype, data: data, bad: bad, now: '0, chk: chk, res: res};
    return w;
  endfunction

  function automatic row_t cfg_row(input logic [2:0] idx, input logic [31:0] data);
    row_t w;
    w = '{op: ROW_CFG, code: 8'(idx), data: '0, bad: 1'b0, now: data, chk: EXP_NONE,
          res: '0};
    return w;
  endfunction

  initial begin
    row_t rows [$];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    snd_idle_pct = 34;
    rcv_idle_pct = 52;

    rows.push_back(tick_row(32'd0, EXP_NONE, '0));
    rows.push_back(tick_row(32'd1500, EXP_GIVEN, mk_result(KIND_BAUD, 32'd1500, 1'b0)));
    rows.push_back(frame_row(TypeAccel, 64'd0, 1'b0, EXP_GIVEN,
                             mk_result(KIND_ACCEL, 32'd0, 1'b0)));
    rows.push_back(frame_row(TypeAngle, 64'h0001_8000_7FFF_FFFF, 1'b0, EXP_MODEL, '0));
    rows.push_back(tick_row(32'd0, EXP_GIVEN, mk_result(KIND_STAMP, 32'd1, 1'b0)));
    rows.push_back(frame_row(TypeGyro, 64'hFFFF_0001_7FFF_8000, 1'b0, EXP_MODEL, '0));
    rows.push_back(frame_row(TypeAngle, 64'h1234_5678_9ABC_DEF0, 1'b1, EXP_NONE, '0));
    // header byte in the type slot is taken as a type and then dropped
    rows.push_back(frame_row(HeaderByte, 64'd0, 1'b0, EXP_NONE, '0));
    rows.push_back(frame_row(TypeBelow, 64'd0, 1'b0, EXP_NONE, '0));
    rows.push_back(frame_row(TypeLow, 64'h0102_0304_0506_0708, 1'b0, EXP_NONE, '0));
    rows.push_back(frame_row(TypeHigh, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, EXP_NONE, '0));
    rows.push_back(frame_row(TypeMag, 64'h8000_8000_8000_8000, 1'b0, EXP_NONE, '0));
    rows.push_back(frame_row(TypeAccel, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, EXP_MODEL, '0));
    rows.push_back(tick_row(32'd999, EXP_NONE, '0));
    rows.push_back(tick_row(32'd1000, EXP_NONE, '0));
    rows.push_back(tick_row(32'd2500, EXP_GIVEN, mk_result(KIND_BAUD, 32'd2500, 1'b1)));
    rows.push_back(cfg_row(CFG_STALE_LIMIT, 32'hFFFF_0000));
    rows.push_back(cfg_row(CFG_PROBE_INTERVAL, 32'h0000_0000));
    rows.push_back(frame_row(TypeAngle, 64'h8000_7FFF_0000_FFFF, 1'b0, EXP_MODEL, '0));
    rows.push_back(tick_row(32'hFFFF_FFFF, EXP_GIVEN,
                            mk_result(KIND_STAMP, 32'hFFFF_FFFF, 1'b0)));
    rows.push_back(tick_row(32'hFFFF_FFFF, EXP_NONE, '0));
    rows.push_back(tick_row(32'd0, EXP_GIVEN, mk_result(KIND_BAUD, 32'd0, 1'b0)));
    rows.push_back(tick_row(32'd5, EXP_GIVEN, mk_result(KIND_BAUD, 32'd5, 1'b1)));

    foreach (rows[i]) begin
      follow_model = (rows[i].chk == EXP_MODEL);
      case (rows[i].op)
        ROW_TICK:  send_tick(rows[i].now);
        ROW_FRAME: send_frame(rows[i].code, rows[i].data, rows[i].bad);
        default: begin
          drain();
          write_reg(rows[i].code[2:0], rows[i].now);
          cfg_valid_i <= 1'b0;
        end
      endcase
      if (rows[i].chk == EXP_GIVEN) decoded_q.push_back(rows[i].res);
    end
    follow_model = 1'b1;

    set_config($urandom, $urandom, $urandom, $urandom,
               {16'($urandom), 16'($urandom_range(50, 400))},
               {16'($urandom), 16'($urandom_range(50, 600))});
    clock_ms = $urandom;
    run_phase(PhaseItems, 150, 1'b0);

    set_config('1, '1, '1, '1, {16'($urandom), 16'd1}, {16'($urandom), 16'hFFFF});
    run_phase(PhaseItems, 3000, 1'b0);

    snd_idle_pct = 52;
    rcv_idle_pct = 34;
    set_config('0, '0, '0, '0, 32'd65535, 32'd1);
    run_phase(PhaseItems, 50, 1'b0);

    set_config(AccelScaleRst, GyroScaleRst, AngleScaleRst, TempScaleRst,
               {16'($urandom), 16'd0}, {16'($urandom), 16'd0});
    run_phase(PhaseItems, 20, 1'b1);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    clock_ms = 32'hFFFF_FF00;
    run_phase(PhaseItems, 200, 1'b0);

    set_config($urandom, $urandom, $urandom, $urandom, 32'd300, 32'd500);
    run_phase(PhaseItems, 100, 1'b1);

    drain();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/imu_sfd_pkg.sv
design/imu_sfd_front.sv
design/imu_sfd_fifo.sv
design/imu_sfd_back.sv
design/imu_serial_frame_decoder_top.sv
dv/tb_imu_serial_frame_decoder_top.sv
